@@ rtl/touch_point_to_color_wheel_defines.svh @@
// Assertion helpers for the top-level RTL file.
// Each expects clk and rst_n to be visible where it is used.
`ifndef TOUCH_POINT_TO_COLOR_WHEEL_DEFINES_SVH
`define TOUCH_POINT_TO_COLOR_WHEEL_DEFINES_SVH

// Same-cycle implication.
`define TPCW_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("touch_point_to_color_wheel: assertion failed");

// Next-cycle implication.
`define TPCW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("touch_point_to_color_wheel: assertion failed");

`endif

@@ rtl/tpcw_pkg.sv @@
package tpcw_pkg;

    // CORDIC step counts
    localparam int VEC_STEPS = 24;
    localparam int ROT_STEPS = 30;

    // datapath widths
    localparam int VEC_W   = 28;  // vectoring x/y (|dx| << 16 plus gain growth)
    localparam int ROT_W   = 33;  // rotation x/y in Q2.30
    localparam int ROT_Z_W = 34;  // rotation residual angle
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 8;

    // angles in 2^-32 turn
    localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [31:0] THIRD_TURN   = 32'h5555_5555;

    localparam logic signed [ROT_W-1:0] CORDIC_GAIN_Q30 = 33'sd652032874;

    localparam logic [CFG_DATA_W-1:0] CENTER_RESET = 8'd120;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_CENTER_X = 1'b0,
        REG_CENTER_Y = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic [31:0]             ang;
        logic                    zero;   // touch right on the center
    } vec_word_t;

    typedef struct packed {
        logic signed [ROT_W-1:0]   x;
        logic signed [ROT_W-1:0]   y;
        logic signed [ROT_Z_W-1:0] z;
        logic                      neg;  // angle was folded by half a turn
    } rot_word_t;

    // atan(2^-i) in 2^-32 turn
    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] val;
        unique case (idx)
            5'd0:    val = 32'd536870912;
            5'd1:    val = 32'd316933406;
            5'd2:    val = 32'd167458907;
            5'd3:    val = 32'd85004756;
            5'd4:    val = 32'd42667331;
            5'd5:    val = 32'd21354465;
            5'd6:    val = 32'd10679838;
            5'd7:    val = 32'd5340245;
            5'd8:    val = 32'd2670163;
            5'd9:    val = 32'd1335087;
            5'd10:   val = 32'd667544;
            5'd11:   val = 32'd333772;
            5'd12:   val = 32'd166886;
            5'd13:   val = 32'd83443;
            5'd14:   val = 32'd41722;
            5'd15:   val = 32'd20861;
            5'd16:   val = 32'd10430;
            5'd17:   val = 32'd5215;
            5'd18:   val = 32'd2608;
            5'd19:   val = 32'd1304;
            5'd20:   val = 32'd652;
            5'd21:   val = 32'd326;
            5'd22:   val = 32'd163;
            5'd23:   val = 32'd81;
            5'd24:   val = 32'd41;
            5'd25:   val = 32'd20;
            5'd26:   val = 32'd10;
            5'd27:   val = 32'd5;
            5'd28:   val = 32'd3;
            5'd29:   val = 32'd1;
            default: val = 32'd0;
        endcase
        return val;
    endfunction

endpackage

@@ rtl/tpcw_vec_cell.sv @@
// One vectoring CORDIC step: drive y toward zero, accumulate angle.
module tpcw_vec_cell #(
    parameter int STEP = 0
) (
    input  logic                clk,
    input  logic                en,
    input  tpcw_pkg::vec_word_t d_in,
    output tpcw_pkg::vec_word_t d_out
);

    logic signed [tpcw_pkg::VEC_W-1:0] x_in;
    logic signed [tpcw_pkg::VEC_W-1:0] y_in;
    logic signed [tpcw_pkg::VEC_W-1:0] x_sh;
    logic signed [tpcw_pkg::VEC_W-1:0] y_sh;
    logic [31:0]                       atan_c;
    tpcw_pkg::vec_word_t               out_reg;
    tpcw_pkg::vec_word_t               out_next;

    assign x_in   = d_in.x;
    assign y_in   = d_in.y;
    assign x_sh   = x_in >>> STEP;
    assign y_sh   = y_in >>> STEP;
    assign atan_c = tpcw_pkg::atan_turn(5'(STEP));

    always_comb
    begin
        out_next = d_in;
        if (!y_in[tpcw_pkg::VEC_W-1] && (y_in != '0))
        begin
            out_next.x   = x_in + y_sh;
            out_next.y   = y_in - x_sh;
            out_next.ang = d_in.ang + atan_c;
        end
        else
        begin
            out_next.x   = x_in - y_sh;
            out_next.y   = y_in + x_sh;
            out_next.ang = d_in.ang - atan_c;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end

    assign d_out = out_reg;

endmodule

@@ rtl/tpcw_rot_cell.sv @@
// One rotation CORDIC step: rotate (x, y) to drive z toward zero.
module tpcw_rot_cell #(
    parameter int STEP = 0
) (
    input  logic                clk,
    input  logic                en,
    input  tpcw_pkg::rot_word_t d_in,
    output tpcw_pkg::rot_word_t d_out
);

    logic signed [tpcw_pkg::ROT_W-1:0]   x_in;
    logic signed [tpcw_pkg::ROT_W-1:0]   y_in;
    logic signed [tpcw_pkg::ROT_Z_W-1:0] z_in;
    logic signed [tpcw_pkg::ROT_W-1:0]   x_sh;
    logic signed [tpcw_pkg::ROT_W-1:0]   y_sh;
    logic signed [tpcw_pkg::ROT_Z_W-1:0] atan_c;
    tpcw_pkg::rot_word_t                 out_reg;
    tpcw_pkg::rot_word_t                 out_next;

    assign x_in   = d_in.x;
    assign y_in   = d_in.y;
    assign z_in   = d_in.z;
    assign x_sh   = x_in >>> STEP;
    assign y_sh   = y_in >>> STEP;
    assign atan_c = {{(tpcw_pkg::ROT_Z_W-32){1'b0}}, tpcw_pkg::atan_turn(5'(STEP))};

    always_comb
    begin
        out_next = d_in;
        if (!z_in[tpcw_pkg::ROT_Z_W-1])
        begin
            out_next.x = x_in - y_sh;
            out_next.y = y_in + x_sh;
            out_next.z = z_in - atan_c;
        end
        else
        begin
            out_next.x = x_in + y_sh;
            out_next.y = y_in - x_sh;
            out_next.z = z_in + atan_c;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end

    assign d_out = out_reg;

endmodule

@@ rtl/touch_point_to_color_wheel.sv @@
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tdata: touch_x[7:0], touch_y[15:8]
// m_*       out  m_tvalid/m_tready  m_tdata: red[7:0], green[15:8], blue[23:16]
// cfg_*     in   cfg_we             cfg_addr selects center_x / center_y
//
// One word in per cycle, one color out per cycle, while the output is not stalled;
// the pipe is the atan2 chain plus the cosine chains and the edge stages pre, round, fold, bias and scale/out.
// rst_n clears the valid bits, the skid slot and the centers (both 120).
// Every stage advances together when the output register is free or being
// taken; while it is stalled, one more input word is held in a skid slot.
// Config writes take effect on the next word that enters the pipe.
`include "touch_point_to_color_wheel_defines.svh"

module touch_point_to_color_wheel #(
    parameter int PHASE_BITS = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [15:0]                       s_tdata,   // touch_x, touch_y
    // output stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [23:0]                       m_tdata,   // red, green, blue
    // register writes
    input  logic                              cfg_we,
    input  logic [tpcw_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [tpcw_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int VEC_STEPS = tpcw_pkg::VEC_STEPS;
    localparam int ROT_STEPS = tpcw_pkg::ROT_STEPS;
    localparam int VEC_W     = tpcw_pkg::VEC_W;
    localparam int ROT_W     = tpcw_pkg::ROT_W;
    localparam int ROT_Z_W   = tpcw_pkg::ROT_Z_W;
    localparam int LANES     = 3;
    // stage map: pre, vec cells, round, fold, rot cells, bias, scale/out
    localparam int LAT       = VEC_STEPS + ROT_STEPS + 5;
    localparam int SUM_W     = ROT_W + 2;
    localparam int PROD_W    = SUM_W + 8;

    localparam logic [31:0] ROUND_HALF = 32'd1 << (31 - PHASE_BITS);
    localparam logic signed [SUM_W-1:0] ONE_Q30 = SUM_W'(2**30);
    // hue offsets: red 0, green -1/3 turn, blue +1/3 turn
    localparam logic [31:0] LANE_OFF [LANES] = '{
        32'h0000_0000,
        32'h0000_0000 - tpcw_pkg::THIRD_TURN,
        tpcw_pkg::THIRD_TURN
    };

    // ---------------- config registers ----------------
    logic [7:0] center_x_reg;
    logic [7:0] center_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= tpcw_pkg::CENTER_RESET;
            center_y_reg <= tpcw_pkg::CENTER_RESET;
        end
        else if (cfg_we)
        begin
            unique case (tpcw_pkg::cfg_reg_t'(cfg_addr))
                tpcw_pkg::REG_CENTER_X: center_x_reg <= cfg_wdata;
                tpcw_pkg::REG_CENTER_Y: center_y_reg <= cfg_wdata;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic           adv;            // all stages move this cycle
    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] vld_next;
    logic           skid_full_reg;
    logic           skid_full_next;
    logic [15:0]    skid_data_reg;
    logic           feed_valid;
    logic [15:0]    feed_data;

    assign adv        = !vld_reg[LAT-1] || m_tready;
    assign s_tready   = !skid_full_reg;
    assign feed_valid = skid_full_reg || s_tvalid;
    assign feed_data  = skid_full_reg ? skid_data_reg : s_tdata;

    always_comb
    begin
        vld_next       = vld_reg;
        skid_full_next = skid_full_reg;
        if (adv)
        begin
            vld_next       = {vld_reg[LAT-2:0], feed_valid};
            skid_full_next = 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            skid_full_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            skid_full_reg <= 1'b0;
        end
        else
        begin
            vld_reg       <= vld_next;
            skid_full_reg <= skid_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!adv && s_tvalid && s_tready)
        begin
            skid_data_reg <= s_tdata;
        end
    end

    // ---------------- pre stage: offset and half-plane fold ----------------
    logic [8:0]          dx9;
    logic [8:0]          dy9;
    logic [8:0]          ax9;
    logic [8:0]          ay9;
    tpcw_pkg::vec_word_t pre_next;
    tpcw_pkg::vec_word_t pre_reg;

    always_comb
    begin
        dx9 = {1'b0, feed_data[7:0]} - {1'b0, center_x_reg};
        dy9 = {1'b0, center_y_reg} - {1'b0, feed_data[15:8]};   // y points up
        // left half-plane: rotate by half a turn so x starts non-negative
        ax9 = dx9[8] ? (9'd0 - dx9) : dx9;
        ay9 = dx9[8] ? (9'd0 - dy9) : dy9;
        pre_next.x    = {{(VEC_W-25){ax9[8]}}, ax9, 16'h0000};
        pre_next.y    = {{(VEC_W-25){ay9[8]}}, ay9, 16'h0000};
        pre_next.ang  = dx9[8] ? tpcw_pkg::HALF_TURN : 32'h0000_0000;
        pre_next.zero = (dx9 == 9'd0) && (dy9 == 9'd0);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pre_reg <= pre_next;
        end
    end

    // ---------------- atan2 chain ----------------
    tpcw_pkg::vec_word_t vec_w [VEC_STEPS+1];

    assign vec_w[0] = pre_reg;

    for (genvar k = 0; k < VEC_STEPS; k++)
    begin : g_vec
        tpcw_vec_cell #(
            .STEP (k)
        ) u_cell (
            .clk   (clk),
            .en    (adv),
            .d_in  (vec_w[k]),
            .d_out (vec_w[k+1])
        );
    end

    // ---------------- round to phase ----------------
    logic [31:0]           ang_eff;
    logic [31:0]           ang_rnd;
    logic [PHASE_BITS-1:0] phase_reg;
    logic [31:0]           base;

    assign ang_eff = vec_w[VEC_STEPS].zero ? 32'h0000_0000 : vec_w[VEC_STEPS].ang;
    assign ang_rnd = ang_eff + ROUND_HALF;
    assign base    = {phase_reg, {(32-PHASE_BITS){1'b0}}};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            phase_reg <= ang_rnd[31 -: PHASE_BITS];
        end
    end

    // ---------------- per-lane fold into +/- quarter turn ----------------
    tpcw_pkg::rot_word_t rot_init_next [LANES];
    tpcw_pkg::rot_word_t rot_init_reg  [LANES];

    always_comb
    begin
        logic [31:0] a;
        logic [31:0] t;
        logic        neg;
        for (int l = 0; l < LANES; l++)
        begin
            a   = base + LANE_OFF[l];
            t   = base + (LANE_OFF[l] + tpcw_pkg::QUARTER_TURN);
            neg = t[31];
            rot_init_next[l].x   = tpcw_pkg::CORDIC_GAIN_Q30;
            rot_init_next[l].y   = '0;
            // folding by half a turn only flips the top bit
            rot_init_next[l].z   = {{(ROT_Z_W-31){a[31] ^ neg}}, a[30:0]};
            rot_init_next[l].neg = neg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rot_init_reg <= rot_init_next;
        end
    end

    // ---------------- cosine chains, one per color ----------------
    tpcw_pkg::rot_word_t rot_w [LANES][ROT_STEPS+1];

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        assign rot_w[l][0] = rot_init_reg[l];
        for (genvar k = 0; k < ROT_STEPS; k++)
        begin : g_rot
            tpcw_rot_cell #(
                .STEP (k)
            ) u_cell (
                .clk   (clk),
                .en    (adv),
                .d_in  (rot_w[l][k]),
                .d_out (rot_w[l][k+1])
            );
        end
    end

    // ---------------- bias, scale by 255, clamp ----------------
    logic signed [SUM_W-1:0] bias_next [LANES];
    logic signed [SUM_W-1:0] bias_reg  [LANES];
    logic [7:0]              color_next [LANES];
    logic [7:0]              color_reg  [LANES];

    always_comb
    begin
        logic signed [SUM_W-1:0] xe;
        for (int l = 0; l < LANES; l++)
        begin
            xe = {{(SUM_W-ROT_W){rot_w[l][ROT_STEPS].x[ROT_W-1]}}, rot_w[l][ROT_STEPS].x};
            bias_next[l] = rot_w[l][ROT_STEPS].neg ? (ONE_Q30 - xe) : (xe + ONE_Q30);
        end
    end

    always_comb
    begin
        logic [PROD_W-1:0] ve;
        logic [PROD_W-1:0] prod;
        for (int l = 0; l < LANES; l++)
        begin
            ve   = {{(PROD_W-SUM_W){1'b0}}, bias_reg[l]};
            prod = (ve << 8) - ve;   // 255 * v, only used when v >= 0
            if (bias_reg[l][SUM_W-1])
            begin
                color_next[l] = 8'd0;
            end
            else if (|prod[PROD_W-1:39])
            begin
                color_next[l] = 8'd255;
            end
            else
            begin
                color_next[l] = prod[38:31];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bias_reg  <= bias_next;
            color_reg <= color_next;
        end
    end

    assign m_tvalid = vld_reg[LAT-1];
    assign m_tdata  = {color_reg[2], color_reg[1], color_reg[0]};

    // ---------------- assertions ----------------
    `TPCW_ASSERT_NEXT(a_skid_holds, skid_full_reg && !adv, skid_full_reg)
    `TPCW_ASSERT_NEXT(a_accept_enters, s_tvalid && s_tready && adv, vld_reg[0])
    `TPCW_ASSERT_NEXT(a_freeze, !adv, vld_reg == $past(vld_reg))
    `TPCW_ASSERT_NEXT(a_center_phase,
        vld_reg[VEC_STEPS] && vec_w[VEC_STEPS].zero && adv, phase_reg == '0)

endmodule
